// ===== hw/rtl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the bilinear image scaler
// Register indexes, fixed-point constants, item kinds, reset values and back-end states.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int FRAC_BITS = 12;
    localparam int COORD_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_INVERSE_SCALE = 2'd2,
        REG_BORDER_MODE   = 2'd3
    } t_reg_idx;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam logic [8:0]  SOURCE_WIDTH_RST  = 9'd256;
    localparam logic [8:0]  SOURCE_HEIGHT_RST = 9'd256;
    localparam logic [15:0] INVERSE_SCALE_RST = 16'd4096;
    localparam logic        BORDER_MODE_RST   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_HBLEND,
        ST_VBLEND,
        ST_ROUND
    } t_back_state;

endpackage

// ===== hw/rtl/bis_if.sv =====
// ----------------------------------------------------------------------------
// bis_if: valid/ready channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface bis_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] col;
    logic [11:0] row;
    logic [1:0]  channel;
    logic [7:0]  value;
    modport source (output valid, kind, col, row, channel, value, input ready);
    modport sink   (input valid, kind, col, row, channel, value, output ready);
endinterface

interface bis_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

interface bis_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bis_front.sv =====
// ----------------------------------------------------------------------------
// bis_front: item classifier
// Maps requests to source coordinates and neighbour addresses with
// border handling; passes writes through. Output is one queue entry.
// ----------------------------------------------------------------------------
module bis_front
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int CHANNELS   = 3,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT),
    parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bis_in_if.sink        in_ch,
    input  logic [8:0]    i_source_width,
    input  logic [8:0]    i_source_height,
    input  logic [15:0]   i_inverse_scale,
    input  logic          i_border_mode,
    output logic          o_valid,
    input  logic          i_ready,
    // packed entry: see bilinear_image_scaler for the layout
    output logic          o_kind,
    output logic          o_bad,
    output logic [XW-1:0] o_x0,
    output logic [XW-1:0] o_x1,
    output logic [YW-1:0] o_y0,
    output logic [YW-1:0] o_y1,
    output logic [3:0]    o_zero,
    output logic [CW-1:0] o_ch,
    output logic [7:0]    o_value,
    output logic [FRAC_BITS-1:0] o_fx,
    output logic [FRAC_BITS-1:0] o_fy
);

    // stage 1: multiply
    logic        r_s1_valid;
    logic        r_s1_kind, r_s1_bad;
    logic [27:0] r_sx, r_sy;
    logic [11:0] r_col, r_row;
    logic [1:0]  r_ch;
    logic [7:0]  r_value;
    logic        r_s2_valid;
    logic        s1_adv, s2_adv;

    logic [12:0] w_eff, h_eff;
    logic [16:0] xl, yl, xh, yh;
    logic        ox0, ox1, oy0, oy1;
    logic [16:0] cx0, cx1, cy0, cy1;

    assign s2_adv = !r_s2_valid || i_ready;
    assign s1_adv = !r_s1_valid || s2_adv;
    assign in_ch.ready = s1_adv;
    assign o_valid = r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= in_ch.valid;
        end
        if (s1_adv && in_ch.valid) begin
            r_s1_kind <= in_ch.kind;
            r_sx      <= in_ch.col * i_inverse_scale;
            r_sy      <= in_ch.row * i_inverse_scale;
            r_col     <= in_ch.col;
            r_row     <= in_ch.row;
            r_ch      <= in_ch.channel;
            r_value   <= in_ch.value;
            r_s1_bad  <= ({30'd0, in_ch.channel} >= 32'(CHANNELS));
        end
    end

    always_comb begin
        if (i_source_width == 9'd0) begin
            w_eff = 13'd1;
        end else if ({4'd0, i_source_width} > 13'(MAX_WIDTH)) begin
            w_eff = 13'(MAX_WIDTH);
        end else begin
            w_eff = {4'd0, i_source_width};
        end
        if (i_source_height == 9'd0) begin
            h_eff = 13'd1;
        end else if ({4'd0, i_source_height} > 13'(MAX_HEIGHT)) begin
            h_eff = 13'(MAX_HEIGHT);
        end else begin
            h_eff = {4'd0, i_source_height};
        end
        xl  = {1'b0, r_sx[27:FRAC_BITS]};
        yl  = {1'b0, r_sy[27:FRAC_BITS]};
        xh  = xl + 17'd1;
        yh  = yl + 17'd1;
        ox0 = xl >= {4'd0, w_eff};
        ox1 = xh >= {4'd0, w_eff};
        oy0 = yl >= {4'd0, h_eff};
        oy1 = yh >= {4'd0, h_eff};
        cx0 = ox0 ? {4'd0, w_eff - 13'd1} : xl;
        cx1 = ox1 ? {4'd0, w_eff - 13'd1} : xh;
        cy0 = oy0 ? {4'd0, h_eff - 13'd1} : yl;
        cy1 = oy1 ? {4'd0, h_eff - 13'd1} : yh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_adv) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_adv && r_s1_valid) begin
            o_kind  <= r_s1_kind;
            o_value <= r_value;
            o_ch    <= r_ch[CW-1:0];
            o_fx    <= r_sx[FRAC_BITS-1:0];
            o_fy    <= r_sy[FRAC_BITS-1:0];
            if (r_s1_kind == KIND_WRITE) begin
                o_bad <= ({20'd0, r_col} >= 32'(MAX_WIDTH)) ||
                         ({20'd0, r_row} >= 32'(MAX_HEIGHT)) || r_s1_bad;
                o_x0  <= r_col[XW-1:0];
                o_y0  <= r_row[YW-1:0];
                o_x1  <= r_col[XW-1:0];
                o_y1  <= r_row[YW-1:0];
                o_zero <= 4'd0;
            end else begin
                o_bad <= r_s1_bad;
                o_x0  <= cx0[XW-1:0];
                o_x1  <= cx1[XW-1:0];
                o_y0  <= cy0[YW-1:0];
                o_y1  <= cy1[YW-1:0];
                // zero flags for p00 p10 p01 p11
                o_zero <= i_border_mode ? 4'd0 :
                          {ox1 | oy1, ox0 | oy1, ox1 | oy0, ox0 | oy0};
            end
        end
    end

endmodule

// ===== hw/rtl/bis_queue.sv =====
// ----------------------------------------------------------------------------
// bis_queue: small FIFO between classifier and executor
// Register-based, power-of-two depth.
// ----------------------------------------------------------------------------
module bis_queue
    import bis_pkg::*;
#(
    parameter int DW    = 64,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW:0]   r_wp, r_rp;
    logic          push, pop;

    assign o_ready = (r_wp - r_rp) != (AW+1)'(DEPTH);
    assign o_valid = r_wp != r_rp;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
        end
        if (push) begin
            r_mem[r_wp[AW-1:0]] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/bis_back.sv =====
// ----------------------------------------------------------------------------
// bis_back: frame store and blend engine
// Holds the frame store with its single read port, performs writes, and for requests
// reads four neighbours then blends along x and y with rounding.
// ----------------------------------------------------------------------------
module bis_back
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int CHANNELS   = 3,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT),
    parameter int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_kind,
    input  logic          i_bad,
    input  logic [XW-1:0] i_x0,
    input  logic [XW-1:0] i_x1,
    input  logic [YW-1:0] i_y0,
    input  logic [YW-1:0] i_y1,
    input  logic [3:0]    i_zero,
    input  logic [CW-1:0] i_ch,
    input  logic [7:0]    i_value,
    input  logic [FRAC_BITS-1:0] i_fx,
    input  logic [FRAC_BITS-1:0] i_fy,
    bis_out_if.source     out_ch
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ONE   = 1 << FRAC_BITS;

    logic [7:0]  r_mem [DEPTH];
    t_back_state r_state, n_state;
    logic [1:0]  r_cnt;
    logic [1:0]  r_rd_idx;
    logic        r_rd_pend;
    logic [7:0]  r_rd;
    logic [7:0]  r_p [4];
    logic [3:0]  r_zero;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic [XW-1:0] r_x0, r_x1;
    logic [YW-1:0] r_y0, r_y1;
    logic [CW-1:0] r_ch;
    logic        r_bad;
    logic [19:0] r_h0, r_h1;
    logic [31:0] r_v;
    logic        r_out_valid;
    logic [7:0]  r_sample;

    logic        take, is_wr, out_free;
    logic [XW-1:0] rx;
    logic [YW-1:0] ry;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [12:0] wx;
    logic [12:0] wy;

    assign o_ready = (r_state == ST_IDLE);
    assign out_free = !r_out_valid || out_ch.ready;
    assign take    = i_valid && o_ready;
    assign is_wr   = take && (i_kind == KIND_WRITE) && !i_bad;
    assign wr_addr = AW'(((i_y0 * MAX_WIDTH) + i_x0) * CHANNELS + i_ch);
    assign out_ch.valid  = r_out_valid;
    assign out_ch.sample = r_sample;
    assign wx = 13'(ONE) - {1'b0, r_fx};
    assign wy = 13'(ONE) - {1'b0, r_fy};

    always_comb begin
        rx = r_cnt[0] ? r_x1 : r_x0;
        ry = r_cnt[1] ? r_y1 : r_y0;
        rd_addr = AW'(((ry * MAX_WIDTH) + rx) * CHANNELS + r_ch);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (take && i_kind == KIND_REQUEST) begin
                n_state = i_bad ? ST_ROUND : ST_FETCH;
            end
            ST_FETCH:  if (r_rd_pend && r_rd_idx == 2'd3) begin
                n_state = ST_HBLEND;
            end
            ST_HBLEND: n_state = ST_VBLEND;
            ST_VBLEND: n_state = ST_ROUND;
            ST_ROUND:  if (out_free) begin
                n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (is_wr) begin
            r_mem[wr_addr] <= i_value;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= 2'd0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_ch.valid && out_ch.ready) r_out_valid <= 1'b0;
            if (r_state == ST_ROUND && out_free) r_out_valid <= 1'b1;
            r_rd_pend <= (r_state == ST_FETCH) && !(r_rd_pend && r_rd_idx == 2'd3)
                         && !(r_cnt == 2'd0 && r_rd_pend);
            if (r_state == ST_FETCH && !(r_cnt == 2'd0 && r_rd_pend)) begin
                r_cnt <= r_cnt + 2'd1;
            end
            if (r_state == ST_IDLE) r_cnt <= 2'd0;
        end
        r_rd_idx <= r_cnt;
        if (take) begin
            r_x0 <= i_x0; r_x1 <= i_x1; r_y0 <= i_y0; r_y1 <= i_y1;
            r_ch <= i_ch; r_fx <= i_fx; r_fy <= i_fy;
            r_zero <= i_zero; r_bad <= i_bad;
        end
        if (r_rd_pend) begin
            r_p[r_rd_idx] <= r_zero[r_rd_idx] ? 8'd0 : r_rd;
        end
        if (r_state == ST_HBLEND) begin
            r_h0 <= 20'(r_p[0]) * 20'(wx) + 20'(r_p[1]) * 20'(r_fx);
            r_h1 <= 20'(r_p[2]) * 20'(wx) + 20'(r_p[3]) * 20'(r_fx);
        end
        if (r_state == ST_VBLEND) begin
            r_v <= 32'(r_h0) * 32'(wy) + 32'(r_h1) * 32'(r_fy) + 32'(1 << 23);
        end
        if (r_state == ST_ROUND && out_free) begin
            r_sample <= r_bad ? 8'd0 : r_v[31:24];
        end
    end

endmodule

// ===== hw/rtl/bilinear_image_scaler.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_scaler: frame-store bilinear resampler
// Stores source samples and returns bilinearly blended output samples.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                            Item
// in_ch    in   kind, col, row, channel, value     write or request
// out_ch   out  sample                             one per request
// cfg_ch   in   index, data                        register write
//
// A request holds the back end while it fetches the four neighbours one by one
// through the single read port of the frame store, then x blend, y blend and
// rounding. A write is stored as the idle back end takes it. The front end maps
// coordinates in two stages and a 4-entry queue decouples it from the back end.
// Rounding waits only while the previous result is still unaccepted.
// Reset is synchronous, active low; the frame store is not cleared.
// ----------------------------------------------------------------------------
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int CHANNELS   = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bis_in_if.sink     in_ch,
    bis_out_if.source  out_ch,
    bis_cfg_if.sink    cfg_ch
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QW = 2 + 2*XW + 2*YW + 4 + CW + 8 + 2*FRAC_BITS;

    logic [8:0]  r_source_width, r_source_height;
    logic [15:0] r_inverse_scale;
    logic        r_border_mode;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= SOURCE_WIDTH_RST;
            r_source_height <= SOURCE_HEIGHT_RST;
            r_inverse_scale <= INVERSE_SCALE_RST;
            r_border_mode   <= BORDER_MODE_RST;
        end else if (cfg_ch.valid) begin
            unique case (t_reg_idx'(cfg_ch.index))
                REG_SOURCE_WIDTH:  r_source_width  <= cfg_ch.data[8:0];
                REG_SOURCE_HEIGHT: r_source_height <= cfg_ch.data[8:0];
                REG_INVERSE_SCALE: r_inverse_scale <= cfg_ch.data;
                REG_BORDER_MODE:   r_border_mode   <= cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    logic          f_valid, f_ready, f_kind, f_bad;
    logic [XW-1:0] f_x0, f_x1;
    logic [YW-1:0] f_y0, f_y1;
    logic [3:0]    f_zero;
    logic [CW-1:0] f_ch;
    logic [7:0]    f_value;
    logic [FRAC_BITS-1:0] f_fx, f_fy;

    logic          b_valid, b_ready, b_kind, b_bad;
    logic [XW-1:0] b_x0, b_x1;
    logic [YW-1:0] b_y0, b_y1;
    logic [3:0]    b_zero;
    logic [CW-1:0] b_ch;
    logic [7:0]    b_value;
    logic [FRAC_BITS-1:0] b_fx, b_fy;
    logic [QW-1:0] q_in, q_out;

    bis_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .CHANNELS(CHANNELS))
    u_front (
        .i_clk, .i_rst_n, .in_ch,
        .i_source_width(r_source_width), .i_source_height(r_source_height),
        .i_inverse_scale(r_inverse_scale), .i_border_mode(r_border_mode),
        .o_valid(f_valid), .i_ready(f_ready), .o_kind(f_kind), .o_bad(f_bad),
        .o_x0(f_x0), .o_x1(f_x1), .o_y0(f_y0), .o_y1(f_y1), .o_zero(f_zero),
        .o_ch(f_ch), .o_value(f_value), .o_fx(f_fx), .o_fy(f_fy)
    );

    assign q_in = {f_kind, f_bad, f_x0, f_x1, f_y0, f_y1, f_zero, f_ch, f_value, f_fx, f_fy};
    assign {b_kind, b_bad, b_x0, b_x1, b_y0, b_y1, b_zero, b_ch, b_value, b_fx, b_fy} = q_out;

    bis_queue #(.DW(QW), .DEPTH(4)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(q_in),
        .o_valid(b_valid), .i_ready(b_ready), .o_data(q_out)
    );

    bis_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .CHANNELS(CHANNELS))
    u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_valid), .o_ready(b_ready), .i_kind(b_kind), .i_bad(b_bad),
        .i_x0(b_x0), .i_x1(b_x1), .i_y0(b_y0), .i_y1(b_y1), .i_zero(b_zero),
        .i_ch(b_ch), .i_value(b_value), .i_fx(b_fx), .i_fy(b_fy),
        .out_ch
    );

endmodule

// ===== tb/bilinear_image_scaler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler_tb: self-checking testbench of the bilinear scaler
// Loads source samples, issues resampling requests under a series of image
// sizes, scales and border modes, and checks every returned sample against
// a bit-exact predictor. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_tb;
    import bis_pkg::*;

    localparam int STORE_W     = 256;
    localparam int STORE_H     = 256;
    localparam int STORE_CH    = 3;
    localparam int STORE_DEPTH = STORE_W * STORE_H * STORE_CH;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 120;
    localparam int RAND_PHASES  = 13;

    typedef struct {
        logic        kind;
        logic [11:0] col;
        logic [11:0] row;
        logic [1:0]  channel;
        logic [7:0]  value;
    } scaler_item_t;

    logic i_clk;
    logic i_rst_n;

    bis_in_if  in_if ();
    bis_out_if out_if ();
    bis_cfg_if cfg_if ();

    bilinear_image_scaler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .cfg_ch  (cfg_if)
    );

    scaler_item_t pending_items[$];
    logic [7:0]   expected_samples[$];
    logic [7:0]   pixel_mem [STORE_DEPTH];
    bit           pixel_written [STORE_DEPTH];

    logic [8:0]  img_width;
    logic [8:0]  img_height;
    logic [15:0] inv_scale;
    logic        border_clamp;

    bit idle_on;
    int errors;
    int in_gap;
    int out_stall;
    int cycle_count;
    int phase_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, 3)) : 0;
    endfunction

    function automatic int eff_dim(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // store address of a neighbour, -1 when it reads as zero
    function automatic int neighbour_addr(int unsigned x, int unsigned y, int unsigned ch);
        int unsigned w;
        int unsigned h;
        w = eff_dim(img_width, STORE_W);
        h = eff_dim(img_height, STORE_H);
        if (x >= w || y >= h) begin
            if (!border_clamp) return -1;
            if (x >= w) x = w - 1;
            if (y >= h) y = h - 1;
        end
        return (y * STORE_W + x) * STORE_CH + ch;
    endfunction

    function automatic void map_point(logic [11:0] col, logic [11:0] row,
                                      output int unsigned xl, output int unsigned yl,
                                      output logic [11:0] fx, output logic [11:0] fy);
        logic [31:0] sx;
        logic [31:0] sy;
        sx = 32'(col) * 32'(inv_scale);
        sy = 32'(row) * 32'(inv_scale);
        xl = sx >> FRAC_BITS;
        yl = sy >> FRAC_BITS;
        fx = sx[11:0];
        fy = sy[11:0];
    endfunction

    function automatic logic [7:0] interp_sample(logic [11:0] col, logic [11:0] row,
                                                 logic [1:0] ch);
        int unsigned xl;
        int unsigned yl;
        logic [11:0] fx;
        logic [11:0] fy;
        longint unsigned px [4];
        longint unsigned h0;
        longint unsigned h1;
        longint unsigned v;
        int a;
        if (ch >= STORE_CH) return 8'd0;
        map_point(col, row, xl, yl, fx, fy);
        for (int k = 0; k < 4; k++) begin
            a = neighbour_addr(xl + (k % 2), yl + (k / 2), ch);
            px[k] = (a < 0) ? 0 : pixel_mem[a];
        end
        h0 = px[0] * (4096 - fx) + px[1] * fx;
        h1 = px[2] * (4096 - fx) + px[3] * fx;
        v  = h0 * (4096 - fy) + h1 * fy;
        v  = (v + (64'd1 << 23)) >> 24;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    task automatic push_write(logic [11:0] col, logic [11:0] row, logic [1:0] ch,
                              logic [7:0] val);
        int a;
        pending_items.push_back('{KIND_WRITE, col, row, ch, val});
        if (col < STORE_W && row < STORE_H && ch < STORE_CH) begin
            a = (row * STORE_W + col) * STORE_CH + ch;
            pixel_mem[a] = val;
            pixel_written[a] = 1'b1;
            phase_count++;
        end
    endtask

    // fills any unwritten neighbour first, so no read hits an empty entry
    task automatic push_request(logic [11:0] col, logic [11:0] row, logic [1:0] ch);
        int unsigned xl;
        int unsigned yl;
        logic [11:0] fx;
        logic [11:0] fy;
        int a;
        if (ch < STORE_CH) begin
            map_point(col, row, xl, yl, fx, fy);
            for (int k = 0; k < 4; k++) begin
                a = neighbour_addr(xl + (k % 2), yl + (k / 2), ch);
                if (a >= 0 && !pixel_written[a])
                    push_write(12'((a / STORE_CH) % STORE_W), 12'(a / (STORE_CH * STORE_W)),
                               2'(a % STORE_CH), 8'($urandom_range(0, 255)));
            end
        end
        pending_items.push_back('{KIND_REQUEST, col, row, ch, 8'($urandom)});
        expected_samples.push_back(interp_sample(col, row, ch));
        phase_count++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_if.valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_SOURCE_WIDTH:  img_width    = data[8:0];
            REG_SOURCE_HEIGHT: img_height   = data[8:0];
            REG_INVERSE_SCALE: inv_scale    = data;
            REG_BORDER_MODE:   border_clamp = data[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [15:0] w, logic [15:0] h, logic [15:0] s, logic b);
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        write_reg(REG_INVERSE_SCALE, s);
        write_reg(REG_BORDER_MODE, 16'(b));
    endtask

    function automatic logic [15:0] rand_dim();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return 16'($urandom_range(1, 16));
        if (sel == 7) return 16'd0;
        if (sel == 8) return 16'($urandom_range(257, 511) | ($urandom & 16'hfe00));
        return 16'($urandom_range(17, 256));
    endfunction

    function automatic logic [15:0] rand_scale();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 16'd0;
        if (sel < 5) return 16'($urandom_range(1024, 8192));
        if (sel < 8) return 16'($urandom_range(1, 65535));
        return 16'd4096;
    endfunction

    task automatic random_phase();
        int maxc;
        int maxr;
        int sel;
        phase_count = 0;
        if (inv_scale == 0) begin
            maxc = 4095;
            maxr = 4095;
        end else begin
            maxc = ((eff_dim(img_width, STORE_W) + 1) * 4096) / inv_scale;
            maxr = ((eff_dim(img_height, STORE_H) + 1) * 4096) / inv_scale;
            if (maxc > 4095) maxc = 4095;
            if (maxr > 4095) maxr = 4095;
        end
        while (phase_count < PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                push_request(12'($urandom_range(0, maxc)), 12'($urandom_range(0, maxr)),
                             2'($urandom_range(0, 2)));
            else if (sel < 70)
                push_request(12'($urandom), 12'($urandom), 2'($urandom));
            else if (sel < 90)
                push_write(12'($urandom_range(0, eff_dim(img_width, STORE_W) - 1)),
                           12'($urandom_range(0, eff_dim(img_height, STORE_H) - 1)),
                           2'($urandom_range(0, 2)), 8'($urandom));
            else
                push_write(12'($urandom), 12'($urandom), 2'($urandom), 8'($urandom));
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        scaler_item_t itm;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_gap <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_gap != 0) begin
                in_gap <= in_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                itm = pending_items.pop_front();
                in_if.valid   <= 1'b1;
                in_if.kind    <= itm.kind;
                in_if.col     <= itm.col;
                in_if.row     <= itm.row;
                in_if.channel <= itm.channel;
                in_if.value   <= itm.value;
                in_gap <= draw_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        int w;
        logic [7:0] exp_sample;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_stall <= 0;
        end else if (out_if.valid && out_if.ready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected result item: sample %0d", out_if.sample);
                errors++;
            end else begin
                exp_sample = expected_samples.pop_front();
                if (out_if.sample !== exp_sample) begin
                    $error("sample mismatch: expected %0d, actual %0d",
                           exp_sample, out_if.sample);
                    errors++;
                end
            end
            w = draw_gap();
            out_stall <= w;
            out_if.ready <= (w == 0);
        end else if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            out_if.ready <= (out_stall == 1);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.kind    = KIND_WRITE;
        in_if.col     = '0;
        in_if.row     = '0;
        in_if.channel = '0;
        in_if.value   = '0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_SOURCE_WIDTH;
        cfg_if.data   = '0;
        errors = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        img_width    = SOURCE_WIDTH_RST;
        img_height   = SOURCE_HEIGHT_RST;
        inv_scale    = INVERSE_SCALE_RST;
        border_clamp = BORDER_MODE_RST;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset geometry, sample extremes, edges, bad channel
        push_write(0, 0, 0, 8'd255);
        push_write(1, 0, 0, 8'd0);
        push_write(0, 1, 0, 8'd255);
        push_write(1, 1, 0, 8'd0);
        push_request(0, 0, 0);
        push_write(300, 5, 0, 8'd1);
        push_write(5, 300, 1, 8'd2);
        push_write(5, 5, 3, 8'd3);
        push_request(255, 255, 1);
        push_request(12'hfff, 12'hfff, 2);
        push_request(0, 0, 3);
        push_request(128, 7, 0);

        // zero size and zero scale
        set_geometry(16'h0000, 16'h0000, 16'h0000, 1'b1);
        push_request(12'hfff, 12'h800, 0);
        push_request(7, 9, 2);
        // oversize, maximum scale, zero border
        set_geometry(16'hffff, 16'h01ff, 16'hffff, 1'b0);
        push_request(0, 0, 0);
        push_request(1, 1, 1);
        push_request(12'hfff, 12'hfff, 2);
        // tiny scale step, zero border
        set_geometry(16'd256, 16'd256, 16'd1, 1'b0);
        push_request(12'hfff, 12'hfff, 0);
        // small image, downscale, zero border at the edge
        set_geometry(16'd3, 16'd2, 16'd6144, 1'b0);
        push_request(1, 1, 0);
        push_request(2, 1, 1);
        set_geometry(16'd3, 16'd2, 16'd2048, 1'b1);
        push_request(5, 3, 2);
        push_request(6, 4, 0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_geometry(rand_dim(), rand_dim(), rand_scale(), 1'($urandom_range(0, 1)));
            idle_on = ($urandom_range(0, 3) != 0);
            random_phase();
        end

        wait_idle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bis_pkg.sv
hw/rtl/bis_if.sv
hw/rtl/bis_front.sv
hw/rtl/bis_queue.sv
hw/rtl/bis_back.sv
hw/rtl/bilinear_image_scaler.sv
tb/bilinear_image_scaler_tb.sv
